/* src/pss_pkg.sv */
package pss_pkg;

	localparam int MAX_ELEMENTS = 256;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int VAL_W        = 32;
	localparam int TGT_W        = 33;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 64;

	localparam logic REG_TARGET_SUM = 1'b0;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [TGT_W-1:0] tgt_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;

endpackage

/* src/pss_if.sv */
interface pss_elem_if;
	logic                             valid;
	logic                             ready;
	logic signed [pss_pkg::VAL_W-1:0] element_value;
	logic                             is_last;

	modport source (output valid, element_value, is_last, input ready);
	modport sink   (input valid, element_value, is_last, output ready);
endinterface

interface pss_res_if;
	logic                             valid;
	logic                             ready;
	logic                             pair_found;
	logic signed [pss_pkg::VAL_W-1:0] first_value;
	logic signed [pss_pkg::VAL_W-1:0] second_value;

	modport source (output valid, pair_found, first_value, second_value, input ready);
	modport sink   (input valid, pair_found, first_value, second_value, output ready);
endinterface

/* src/pair_sum_search.sv */
// Channel | Dir | Payload                                   | Transfer
// elem    | in  | element_value[31:0] s, is_last            | valid & ready
// res     | out | pair_found, first_value s, second_value s | valid & ready
// apb     | in  | target_sum[32:0] s at byte address 0      | psel & penable & pwrite
//
// Elements load one per cycle; elem.ready is low from the last element until the
// result enters the output register. A list of n elements searches up to
// n*(n-1)/2 pairs, one pair per cycle through the shared adder and comparator.
// The result sits in an output register; loading resumes while it waits.
// arst_n clears the count, sequencer and output valid; the store needs no clearing.
module pair_sum_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pss_pkg::PADDR_W-1:0]   paddr,
	input  logic [pss_pkg::PDATA_W-1:0]   pwdata,
	output logic [pss_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	pss_elem_if.sink                      elem,
	pss_res_if.source                     res
);
	import pss_pkg::*;

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	cnt_t       count_q;
	idx_t       i_q, j_q;
	tgt_t       target_q;
	logic       cmp_vld_s1;
	logic       pend_found_q;
	val_t       pend_a_q, pend_b_q;
	logic       res_vld_q;
	logic       found_q;
	val_t       first_q, second_q;

	logic       in_xfer, full, we, last_j, last_i, match, out_load;
	val_t       rd_a_s1, rd_b_s1;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_TARGET_SUM) ? PDATA_W'({1'b0, target_q}) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && paddr[3] == REG_TARGET_SUM) begin
			target_q <= tgt_t'(pwdata[TGT_W-1:0]);
		end
	end

	assign elem.ready = (state_q == ST_LOAD);
	assign in_xfer    = elem.valid && elem.ready;
	assign full       = (count_q == cnt_t'(MAX_ELEMENTS));
	assign we         = in_xfer && !full;
	assign last_j     = ({1'b0, j_q} == count_q - cnt_t'(1));
	assign last_i     = ({1'b0, i_q} == count_q - cnt_t'(2));
	assign out_load   = (state_q == ST_DONE) && (!res_vld_q || res.ready);

	pss_store u_store (
		.clk        (clk),
		.we         (we),
		.waddr      (count_q[IDX_W-1:0]),
		.wdata      (elem.element_value),
		.raddr_a    (i_q),
		.raddr_b    (j_q),
		.rdata_a_s1 (rd_a_s1),
		.rdata_b_s1 (rd_b_s1)
	);

	pss_sum_cmp u_cmp (
		.a      (rd_a_s1),
		.b      (rd_b_s1),
		.target (target_q),
		.match  (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SEARCH) && !(cmp_vld_s1 && match);
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (!full) begin
							count_q <= count_q + cnt_t'(1);
						end
						if (elem.is_last) begin
							i_q     <= '0;
							j_q     <= idx_t'(1);
							state_q <= (count_q == '0) ? ST_DONE : ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (cmp_vld_s1 && match) begin
						state_q <= ST_DONE;
					end else if (last_j) begin
						if (last_i) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + idx_t'(1);
							j_q <= i_q + idx_t'(2);
						end
					end else begin
						j_q <= j_q + idx_t'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						count_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// capture the outcome of the search
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			pend_found_q <= 1'b0;
			pend_a_q     <= '0;
			pend_b_q     <= '0;
		end else if ((state_q == ST_SEARCH || state_q == ST_DRAIN) && cmp_vld_s1 && match) begin
			pend_found_q <= 1'b1;
			pend_a_q     <= rd_a_s1;
			pend_b_q     <= rd_b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q  <= pend_found_q;
			first_q  <= pend_a_q;
			second_q <= pend_b_q;
		end
	end

	assign res.valid        = res_vld_q;
	assign res.pair_found   = found_q;
	assign res.first_value  = first_q;
	assign res.second_value = second_q;

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> i_q < j_q)
		else $error("pair indices out of order");

	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> {1'b0, j_q} < count_q)
		else $error("pair index beyond list");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_ELEMENTS))
		else $error("element count overflow");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_DONE)
		else $error("drain did not finish");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !found_q) |-> (first_q == '0 && second_q == '0))
		else $error("miss result carries values");
endmodule

/* src/pss_store.sv */
module pss_store (
	input  logic          clk,
	input  logic          we,
	input  pss_pkg::idx_t waddr,
	input  pss_pkg::val_t wdata,
	input  pss_pkg::idx_t raddr_a,
	input  pss_pkg::idx_t raddr_b,
	output pss_pkg::val_t rdata_a_s1,
	output pss_pkg::val_t rdata_b_s1
);
	import pss_pkg::*;

	val_t mem [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_s1 <= mem[raddr_a];
		rdata_b_s1 <= mem[raddr_b];
	end
endmodule

/* src/pss_sum_cmp.sv */
module pss_sum_cmp (
	input  pss_pkg::val_t a,
	input  pss_pkg::val_t b,
	input  pss_pkg::tgt_t target,
	output logic          match
);
	import pss_pkg::*;

	tgt_t sum;

	assign sum   = TGT_W'(a) + TGT_W'(b);
	assign match = (sum == target);
endmodule
